FILE: rtl/core/ief_pkg.sv
// ----------------------------------------------------------------------------
// ief_pkg
// Types, constants and helpers shared by the importance-evicting FIFO core.
// ----------------------------------------------------------------------------
`default_nettype none

package ief_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PAYLOAD_W   = 32;
    localparam int IMP_W       = 8;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    typedef struct packed {
        logic                 command;
        logic [PAYLOAD_W-1:0] payload_in;
        logic                 spoken_in;
        logic [IMP_W-1:0]     importance_in;
    } in_item_t;

    typedef struct packed {
        logic                 accepted;
        logic                 evicted;
        logic [PAYLOAD_W-1:0] payload_out;
        logic                 spoken_out;
        logic [IMP_W-1:0]     importance_out;
        logic [CNT_W-1:0]     queue_length;
    } out_item_t;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic                 spoken;
        logic [IMP_W-1:0]     importance;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DEQ,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_APPEND,
        S_RESP
    } state_t;

    typedef struct packed {
        logic take_req;
        logic rd_head;
        logic deq_done;
        logic res_empty;
        logic append;
        logic append_evict;
        logic scan_init;
        logic scan_step;
        logic evict_head;
        logic shift_init;
        logic shift_step;
        logic shift_finish;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_deq;
        logic empty;
        logic full;
        logic scan_done;
        logic drop;
        logic min_is_head;
        logic shift_done;
        logic out_free;
    } sts_t;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(QUEUE_DEPTH - 1) : i - 1'b1;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ief_ram.sv
// ----------------------------------------------------------------------------
// ief_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ief_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/ief_ctrl.sv
// ----------------------------------------------------------------------------
// ief_ctrl
// Sequencer for enqueue, dequeue, full-queue scan, eviction and shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ief_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire ief_pkg::sts_t sts,
    output ief_pkg::cmd_t      cmd
);

    ief_pkg::state_t state_reg;
    ief_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ief_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ief_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ief_pkg::S_EXEC;
                end
            end
            ief_pkg::S_EXEC:
            begin
                priority if (sts.is_deq && sts.empty)
                begin
                    state_next = ief_pkg::S_RESP;
                end
                else if (sts.is_deq)
                begin
                    state_next = ief_pkg::S_DEQ;
                end
                else if (sts.full)
                begin
                    state_next = ief_pkg::S_SCAN;
                end
                else
                begin
                    state_next = ief_pkg::S_RESP;
                end
            end
            ief_pkg::S_DEQ:
            begin
                state_next = ief_pkg::S_RESP;
            end
            ief_pkg::S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ief_pkg::S_DECIDE;
                end
            end
            ief_pkg::S_DECIDE:
            begin
                priority if (sts.drop)
                begin
                    state_next = ief_pkg::S_RESP;
                end
                else if (sts.min_is_head)
                begin
                    state_next = ief_pkg::S_APPEND;
                end
                else
                begin
                    state_next = ief_pkg::S_SHIFT;
                end
            end
            ief_pkg::S_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    state_next = ief_pkg::S_APPEND;
                end
            end
            ief_pkg::S_APPEND:
            begin
                state_next = ief_pkg::S_RESP;
            end
            ief_pkg::S_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = ief_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ief_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            ief_pkg::S_IDLE:
            begin
                req_stall    = 1'b0;
                cmd.take_req = req_valid;
            end
            ief_pkg::S_EXEC:
            begin
                priority if (sts.is_deq && sts.empty)
                begin
                    cmd.res_empty = 1'b1;
                end
                else if (sts.is_deq)
                begin
                    cmd.rd_head = 1'b1;
                end
                else if (sts.full)
                begin
                    cmd.scan_init = 1'b1;
                end
                else
                begin
                    cmd.append = 1'b1;
                end
            end
            ief_pkg::S_DEQ:
            begin
                cmd.deq_done = 1'b1;
            end
            ief_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ief_pkg::S_DECIDE:
            begin
                priority if (sts.drop)
                begin
                    cmd.res_empty = 1'b1;
                end
                else if (sts.min_is_head)
                begin
                    cmd.evict_head = 1'b1;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                end
            end
            ief_pkg::S_SHIFT:
            begin
                cmd.shift_step   = 1'b1;
                cmd.shift_finish = sts.shift_done;
            end
            ief_pkg::S_APPEND:
            begin
                cmd.append       = 1'b1;
                cmd.append_evict = 1'b1;
            end
            ief_pkg::S_RESP:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ief_pkg::S_SCAN |=>
            state_reg == ief_pkg::S_SCAN || state_reg == ief_pkg::S_DECIDE)
        else $error("scan left to an unexpected state");

    a_shift_not_head: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ief_pkg::S_SHIFT |-> !sts.min_is_head)
        else $error("shift entered with minimum at head");

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_req |=> state_reg == ief_pkg::S_EXEC)
        else $error("request taken without execute");

endmodule

`default_nettype wire

FILE: rtl/core/ief_dpath.sv
// ----------------------------------------------------------------------------
// ief_dpath
// Ring pointers, entry RAM, minimum scan, shift-down and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ief_dpath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ief_pkg::in_item_t req,
    input  wire logic              rsp_stall,
    output logic                   rsp_valid,
    output ief_pkg::out_item_t     rsp,
    input  wire ief_pkg::cmd_t     cmd,
    output ief_pkg::sts_t          sts
);

    localparam int IDX_W = ief_pkg::IDX_W;
    localparam int CNT_W = ief_pkg::CNT_W;
    localparam int IMP_W = ief_pkg::IMP_W;

    ief_pkg::in_item_t  req_reg;
    ief_pkg::out_item_t res_reg;
    ief_pkg::out_item_t out_reg;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic [IDX_W-1:0] scan_addr_reg;
    logic [CNT_W-1:0] iss_cnt_reg;
    logic [CNT_W-1:0] iss_cnt_next;
    logic [CNT_W-1:0] cmp_cnt_reg;
    logic [CNT_W-1:0] cmp_cnt_next;
    logic             rdv_reg;
    logic             rdv_next;
    logic [IDX_W-1:0] rd_idx_d_reg;
    logic [IMP_W-1:0] min_imp_reg;
    logic [IDX_W-1:0] min_idx_reg;

    logic [IDX_W-1:0] cur_reg;
    logic             pend_reg;
    logic             pend_next;
    logic [IDX_W-1:0] pend_addr_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    ief_pkg::entry_t  ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ief_pkg::ENTRY_W-1:0] ram_rdata;
    ief_pkg::entry_t  rd_entry;

    logic [IDX_W-1:0] last_idx;
    logic             scan_issue;
    logic             cur_at_last;

    assign rd_entry    = ief_pkg::entry_t'(ram_rdata);
    assign last_idx    = ief_pkg::prev_slot(tail_reg);
    assign scan_issue  = cmd.scan_step && (iss_cnt_reg < CNT_W'(ief_pkg::QUEUE_DEPTH));
    assign cur_at_last = (cur_reg == last_idx);

    ief_ram #(
        .WIDTH (ief_pkg::ENTRY_W),
        .DEPTH (ief_pkg::QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = tail_reg;
        ram_wdata.payload    = req_reg.payload_in;
        ram_wdata.spoken     = req_reg.spoken_in;
        ram_wdata.importance = req_reg.importance_in;
        if (cmd.append)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.shift_step && pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = rd_entry;
        end
    end

    always_comb
    begin
        ram_raddr = head_reg;
        if (cmd.rd_head)
        begin
            ram_raddr = head_reg;
        end
        else if (cmd.scan_step)
        begin
            ram_raddr = scan_addr_reg;
        end
        else if (cmd.shift_step)
        begin
            ram_raddr = ief_pkg::next_slot(cur_reg);
        end
    end

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        iss_cnt_next = iss_cnt_reg;
        cmp_cnt_next = cmp_cnt_reg;
        rdv_next     = rdv_reg;
        pend_next    = pend_reg;
        if (cmd.deq_done)
        begin
            head_next  = ief_pkg::next_slot(head_reg);
            count_next = count_reg - 1'b1;
        end
        if (cmd.evict_head)
        begin
            head_next  = ief_pkg::next_slot(head_reg);
            count_next = count_reg - 1'b1;
        end
        if (cmd.shift_finish)
        begin
            tail_next  = last_idx;
            count_next = count_reg - 1'b1;
        end
        if (cmd.append)
        begin
            tail_next  = ief_pkg::next_slot(tail_reg);
            count_next = count_reg + 1'b1;
        end
        if (cmd.scan_init)
        begin
            iss_cnt_next = '0;
            cmp_cnt_next = '0;
            rdv_next     = 1'b0;
        end
        if (cmd.scan_step)
        begin
            rdv_next = scan_issue;
            if (scan_issue)
            begin
                iss_cnt_next = iss_cnt_reg + 1'b1;
            end
            if (rdv_reg)
            begin
                cmp_cnt_next = cmp_cnt_reg + 1'b1;
            end
        end
        if (cmd.shift_init)
        begin
            pend_next = 1'b0;
        end
        if (cmd.shift_step)
        begin
            pend_next = !cur_at_last;
        end
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            iss_cnt_reg   <= '0;
            cmp_cnt_reg   <= '0;
            rdv_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            iss_cnt_reg   <= iss_cnt_next;
            cmp_cnt_reg   <= cmp_cnt_next;
            rdv_reg       <= rdv_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_req)
        begin
            req_reg <= req;
        end
        if (cmd.scan_init)
        begin
            scan_addr_reg <= head_reg;
        end
        if (scan_issue)
        begin
            scan_addr_reg <= ief_pkg::next_slot(scan_addr_reg);
            rd_idx_d_reg  <= scan_addr_reg;
        end
        if (cmd.scan_step && rdv_reg)
        begin
            if ((cmp_cnt_reg == '0) || (rd_entry.importance < min_imp_reg))
            begin
                min_imp_reg <= rd_entry.importance;
                min_idx_reg <= rd_idx_d_reg;
            end
        end
        if (cmd.shift_init)
        begin
            cur_reg <= min_idx_reg;
        end
        if (cmd.shift_step && !cur_at_last)
        begin
            cur_reg       <= ief_pkg::next_slot(cur_reg);
            pend_addr_reg <= cur_reg;
        end
        if (cmd.res_empty)
        begin
            res_reg <= '0;
        end
        if (cmd.deq_done)
        begin
            res_reg <= '{accepted:       1'b1,
                         evicted:        1'b0,
                         payload_out:    rd_entry.payload,
                         spoken_out:     rd_entry.spoken,
                         importance_out: rd_entry.importance,
                         queue_length:   '0};
        end
        if (cmd.append)
        begin
            res_reg <= '{accepted:       1'b1,
                         evicted:        cmd.append_evict,
                         payload_out:    '0,
                         spoken_out:     1'b0,
                         importance_out: '0,
                         queue_length:   '0};
        end
        if (cmd.load_out)
        begin
            out_reg <= '{accepted:       res_reg.accepted,
                         evicted:        res_reg.evicted,
                         payload_out:    res_reg.payload_out,
                         spoken_out:     res_reg.spoken_out,
                         importance_out: res_reg.importance_out,
                         queue_length:   count_reg};
        end
    end

    always_comb
    begin
        sts.is_deq      = (req_reg.command == ief_pkg::CMD_DEQUEUE);
        sts.empty       = (count_reg == '0);
        sts.full        = (count_reg == CNT_W'(ief_pkg::QUEUE_DEPTH));
        sts.scan_done   = rdv_reg && (cmp_cnt_reg == CNT_W'(ief_pkg::QUEUE_DEPTH - 1));
        sts.drop        = (req_reg.importance_in <= min_imp_reg);
        sts.min_is_head = (min_idx_reg == head_reg);
        sts.shift_done  = cur_at_last && !pend_reg;
        sts.out_free    = !out_valid_reg || !rsp_stall;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ief_pkg::QUEUE_DEPTH))
        else $error("entry count above depth");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == tail_reg) ==
            ((count_reg == '0) || (count_reg == CNT_W'(ief_pkg::QUEUE_DEPTH))))
        else $error("ring pointers disagree with entry count");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.evicted |->
            out_reg.queue_length == CNT_W'(ief_pkg::QUEUE_DEPTH))
        else $error("eviction reported on a queue that is not full");

endmodule

`default_nettype wire

FILE: rtl/core/importance_evicting_fifo_core.sv
// ----------------------------------------------------------------------------
// importance_evicting_fifo_core
// Bounded FIFO; when full, evicts its first least-important entry or drops.
//
//   channel | signals                    | direction
//   --------+----------------------------+----------
//   request | req_valid, req_stall, req  | in
//   result  | rsp_valid, rsp_stall, rsp  | out
//
// One request at a time. Enqueue on a full queue runs the minimum scan
// and, unless the request is dropped or the minimum sits at the head,
// the shift-down; each does one RAM read per entry.
// Reset clears pointers and count; entry RAM needs no clearing.
// A stalled result holds in its output register; the next request is
// taken meanwhile and waits for that register before its result loads.
// ----------------------------------------------------------------------------
`default_nettype none

module importance_evicting_fifo_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire ief_pkg::in_item_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output ief_pkg::out_item_t     rsp
);

    ief_pkg::cmd_t cmd;
    ief_pkg::sts_t sts;

    ief_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ief_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

FILE: verif/importance_evicting_fifo_checker.sv
// ----------------------------------------------------------------------------
// importance_evicting_fifo_checker
// Watches both channels of the importance-evicting FIFO core. Every accepted
// request runs through a shadow queue that predicts its result. Every
// accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module importance_evicting_fifo_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  ief_pkg::in_item_t  req,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  ief_pkg::out_item_t rsp,
    output int                 mismatch_count,
    output int                 pending_results
);
    import ief_pkg::*;

    entry_t           shadow_slot [QUEUE_DEPTH];
    logic [IDX_W-1:0] shadow_head;
    logic [IDX_W-1:0] shadow_tail;
    logic [CNT_W-1:0] shadow_count;
    out_item_t        due_results [$];
    int               errors;

    function automatic logic [IDX_W-1:0] step_slot(input logic [IDX_W-1:0] i);
        return (int'(i) == QUEUE_DEPTH - 1) ? '0 : i + 1'b1;
    endfunction

    function automatic out_item_t shadow_apply(input in_item_t r);
        out_item_t        res;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] min_idx;
        logic [IMP_W-1:0] min_imp;
        logic [IDX_W-1:0] last;
        res = '0;
        if (r.command == CMD_DEQUEUE)
        begin
            if (shadow_count != 0)
            begin
                res.accepted       = 1'b1;
                res.payload_out    = shadow_slot[shadow_head].payload;
                res.spoken_out     = shadow_slot[shadow_head].spoken;
                res.importance_out = shadow_slot[shadow_head].importance;
                shadow_head        = step_slot(shadow_head);
                shadow_count       = shadow_count - 1'b1;
            end
            res.queue_length = shadow_count;
            return res;
        end
        if (int'(shadow_count) == QUEUE_DEPTH)
        begin
            idx     = shadow_head;
            min_idx = shadow_head;
            min_imp = shadow_slot[shadow_head].importance;
            for (int k = 0; k < QUEUE_DEPTH; k++)
            begin
                if (shadow_slot[idx].importance < min_imp)
                begin
                    min_imp = shadow_slot[idx].importance;
                    min_idx = idx;
                end
                idx = step_slot(idx);
            end
            // not more important than the weakest entry: dropped
            if (r.importance_in <= min_imp)
            begin
                res.queue_length = shadow_count;
                return res;
            end
            if (min_idx == shadow_head)
            begin
                shadow_head = step_slot(shadow_head);
            end
            else
            begin
                last = (shadow_tail == '0) ? IDX_W'(QUEUE_DEPTH - 1) : shadow_tail - 1'b1;
                idx  = min_idx;
                while (idx != last)
                begin
                    shadow_slot[idx] = shadow_slot[step_slot(idx)];
                    idx              = step_slot(idx);
                end
                shadow_tail = last;
            end
            shadow_count = shadow_count - 1'b1;
            res.evicted  = 1'b1;
        end
        shadow_slot[shadow_tail] = {r.payload_in, r.spoken_in, r.importance_in};
        shadow_tail              = step_slot(shadow_tail);
        shadow_count             = shadow_count + 1'b1;
        res.accepted             = 1'b1;
        res.queue_length         = shadow_count;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_item_t want;
        if (!rst_n)
        begin
            shadow_head  = '0;
            shadow_tail  = '0;
            shadow_count = '0;
            due_results.delete();
            errors          = 0;
            mismatch_count  <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none actual %0h",
                             $time, rsp);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("accepted", 64'(want.accepted), 64'(rsp.accepted));
                    check_field("evicted", 64'(want.evicted), 64'(rsp.evicted));
                    check_field("payload_out", 64'(want.payload_out),
                                64'(rsp.payload_out));
                    check_field("spoken_out", 64'(want.spoken_out), 64'(rsp.spoken_out));
                    check_field("importance_out", 64'(want.importance_out),
                                64'(rsp.importance_out));
                    check_field("queue_length", 64'(want.queue_length),
                                64'(rsp.queue_length));
                end
            end
            if (req_valid && !req_stall)
                due_results.push_back(shadow_apply(req));
            mismatch_count  <= errors;
            pending_results <= due_results.size();
        end
    end

endmodule

FILE: verif/importance_evicting_fifo_core_tb.sv
// ----------------------------------------------------------------------------
// importance_evicting_fifo_core_tb
// Drives enqueue and dequeue requests into the importance-evicting FIFO core:
// a directed pass over empty, full, drop and eviction cases, then random
// traffic biased toward a full queue, with idle gaps on both channels, a
// burst with no gaps, a long result hold-off and a full drain.
// ----------------------------------------------------------------------------
module importance_evicting_fifo_core_tb;
    import ief_pkg::*;

    typedef enum int {
        PH_DIRECTED,
        PH_RANDOM,
        PH_BURST,
        PH_PRESSURE
    } phase_t;

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 600000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    in_item_t  req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    out_item_t rsp;
    int        mismatch_count;
    int        pending_results;
    phase_t    phase       = PH_DIRECTED;
    int        cycle_count = 0;
    int        hold_left   = 0;
    bit        hold_used   = 1'b0;
    int        sent        = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    importance_evicting_fifo_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    importance_evicting_fifo_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp             (rsp),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("importance_evicting_fifo_core verification failed");
            $finish;
        end
    end

    // result side: random stall, none during the burst, one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else if (phase == PH_PRESSURE && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (phase == PH_BURST)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < 30);
        end
    end

    function automatic in_item_t enq_item(input logic [PAYLOAD_W-1:0] pay,
                                          input logic spk, input logic [IMP_W-1:0] imp);
        in_item_t r;
        r.command       = CMD_ENQUEUE;
        r.payload_in    = pay;
        r.spoken_in     = spk;
        r.importance_in = imp;
        return r;
    endfunction

    function automatic in_item_t rand_item(input int enq_pct, input int imp_lo,
                                           input int imp_hi);
        in_item_t r;
        r.command       = ($urandom_range(99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
        r.payload_in    = $urandom;
        r.spoken_in     = 1'($urandom_range(1));
        r.importance_in = IMP_W'($urandom_range(imp_hi, imp_lo));
        return r;
    endfunction

    task automatic send(input in_item_t it);
        req       <= it;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        sent++;
        if ((phase == PH_DIRECTED || phase == PH_RANDOM) && $urandom_range(99) < 30)
        begin
            req_valid <= 1'b0;
            req       <= rand_item(50, 0, 255);
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
    endtask

    task automatic random_segments(input int count);
        int target;
        int pattern;
        int base;
        target = sent + count;
        while (sent < target)
        begin
            pattern = $urandom_range(0, 9);
            base    = $urandom_range(0, 248);
            if (pattern < 4)
                repeat (24) send(rand_item(90, base, base + 7)); // full queue, close ties
            else if (pattern < 7)
                repeat (20) send(rand_item(60, 0, 255));
            else if (pattern == 7)
                repeat (20) send(rand_item(10, 0, 255));         // drain past empty
            else
                repeat (10) send(rand_item(50, 0, 255));
        end
    endtask

    initial
    begin
        logic [IMP_W-1:0] fill_imp [16];
        fill_imp = '{3, 200, 255, 180, 9, 3, 3, 120, 77, 64, 150, 31, 240, 12, 90, 201};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(rand_item(0, 0, 255));                          // dequeue on empty
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send(enq_item((i == 0) ? '0 : (i == 2) ? '1 : PAYLOAD_W'($urandom),
                          i[1], fill_imp[i % 16]));
        send(enq_item('1, 1'b1, 8'd3));                      // equal to minimum: dropped
        send(enq_item('0, 1'b0, 8'd0));                      // lowest importance: dropped
        send(enq_item(32'hA5A5_5A5A, 1'b1, 8'd4));           // minimum at head
        send(enq_item(32'h5A5A_A5A5, 1'b0, 8'd100));         // tied minimum mid-queue
        send(rand_item(0, 0, 255));
        send(rand_item(0, 0, 255));

        phase <= PH_RANDOM;
        random_segments(350);
        phase <= PH_BURST;
        random_segments(150);
        phase <= PH_RANDOM;
        wait_drained();
        phase <= PH_PRESSURE;
        repeat (40) send(rand_item(85, 0, 255));
        phase <= PH_RANDOM;
        random_segments(560);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("importance_evicting_fifo_core verification clean");
        else
            $display("importance_evicting_fifo_core verification failed");
        $finish;
    end

endmodule
